FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RHC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define RHC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Types, constants and the reciprocal table of the RGB/HSL converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

	localparam int HUE_FRAC_BITS  = 6;
	localparam int UNIT_FRAC_BITS = 12;
	localparam int UNIT_ONE       = 1 << UNIT_FRAC_BITS;
	localparam int HUE_60         = 60 << HUE_FRAC_BITS;
	localparam int HUE_360        = 360 << HUE_FRAC_BITS;
	localparam int RECIP_SHIFT    = 24;
	localparam int FIFO_DEPTH     = 4;

	typedef enum logic {
		DIR_RGB2HSL = 1'b0,
		DIR_HSL2RGB = 1'b1
	} dir_t;

	localparam logic REG_DIRECTION = 1'b0;

	typedef struct packed {
		logic [7:0]  in_red;
		logic [7:0]  in_green;
		logic [7:0]  in_blue;
		logic [14:0] in_hue;
		logic [12:0] in_sat;
		logic [12:0] in_light;
	} pix_in_t;

	typedef struct packed {
		logic [7:0]  out_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
		logic [14:0] out_hue;
		logic [12:0] out_sat;
		logic [12:0] out_light;
		logic        range_error;
	} pix_out_t;

	typedef struct packed {
		dir_t        dir;
		logic        err;
		logic [23:0] nh;
		logic [23:0] ns;
		logic [23:0] nl;
		logic [7:0]  c;
		logic [7:0]  d;
		logic [24:0] cs;
		logic [12:0] l;
		logic [11:0] w;
		logic [2:0]  sector;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef logic [24:0] recip_tab_t [256];

	function automatic logic [24:0] recip_of(input int dv);
		logic [25:0] rem;
		logic [24:0] q;
		rem = '0;
		q = '0;
		for (int i = RECIP_SHIFT; i >= 0; i--) begin
			rem = {rem[24:0], (i == RECIP_SHIFT)};
			if (dv != 0 && rem >= 26'(dv)) begin
				rem = rem - 26'(dv);
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic recip_tab_t build_recip();
		recip_tab_t tab;
		for (int k = 0; k < 256; k++) begin
			tab[k] = recip_of(k);
		end
		return tab;
	endfunction

	localparam recip_tab_t  RECIP_TAB = build_recip();
	localparam logic [24:0] RECIP_510 = recip_of(510);

endpackage

`default_nettype wire

FILE: rtl/core/rhc_div.sv
// ----------------------------------------------------------------------------
// rhc_div
// Three-stage divider by an up-to-9-bit divisor using a reciprocal estimate
// and one correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [23:0] n,
	input  wire logic [8:0]  dv,
	input  wire logic [24:0] recip,
	output logic      [14:0] q
);

	localparam int RECIP_SHIFT_HI = rhc_pkg::RECIP_SHIFT + 14;

	logic [48:0] prod_s1;
	logic [23:0] n_s1;
	logic [8:0]  dv_s1;
	logic [14:0] q0_s2;
	logic [23:0] qd_s2;
	logic [23:0] n_s2;
	logic [8:0]  dv_s2;
	logic [14:0] q0;
	logic [23:0] rem;

	assign q0  = prod_s1[RECIP_SHIFT_HI:rhc_pkg::RECIP_SHIFT];
	assign rem = n_s2 - qd_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 49'(n) * 49'(recip);
			n_s1    <= n;
			dv_s1   <= dv;
			q0_s2   <= q0;
			qd_s2   <= 24'(q0) * 24'(dv_s1);
			n_s2    <= n_s1;
			dv_s2   <= dv_s1;
			q       <= (rem >= 24'(dv_s2)) ? q0_s2 + 15'd1 : q0_s2;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// Accepts pixels, checks the HSL range and prepares the operands that the
// back end divides or scales.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                direction,
	input  wire logic                src_valid,
	output logic                     src_stall,
	input  wire rhc_pkg::pix_in_t    src_data,
	input  wire rhc_pkg::fifo_stat_t fifo_stat,
	output logic                     push,
	output rhc_pkg::item_t           push_item
);

	logic           fr_v_q;
	rhc_pkg::item_t item_q;
	rhc_pkg::item_t item;
	logic           take;

	logic [7:0]  r, g, b, mx, mn, c;
	logic [8:0]  sum;
	logic [10:0] total;
	logic [14:0] h;
	logic [11:0] hm;
	logic [2:0]  sector;
	logic [13:0] two_l, dev;
	logic [12:0] onemin;

	assign push      = fr_v_q && !fifo_stat.full;
	assign take      = !fr_v_q || !fifo_stat.full;
	assign src_stall = !take;
	assign push_item = item_q;

	always_comb begin
		r = src_data.in_red;
		g = src_data.in_green;
		b = src_data.in_blue;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		c = mx - mn;
		sum = 9'(mx) + 9'(mn);
		if (mx == r) begin
			total = (g >= b) ? 11'(g - b) : 11'(6) * 11'(c) - 11'(b - g);
		end else if (mx == g) begin
			total = 11'(2) * 11'(c) + 11'(b) - 11'(r);
		end else begin
			total = 11'(4) * 11'(c) + 11'(r) - 11'(g);
		end

		h = (src_data.in_hue == 15'(rhc_pkg::HUE_360)) ? 15'd0 : src_data.in_hue;
		if (h >= 15'(5 * rhc_pkg::HUE_60)) begin
			sector = 3'd5;
			hm = 12'(h - 15'(5 * rhc_pkg::HUE_60));
		end else if (h >= 15'(4 * rhc_pkg::HUE_60)) begin
			sector = 3'd4;
			hm = 12'(h - 15'(4 * rhc_pkg::HUE_60));
		end else if (h >= 15'(3 * rhc_pkg::HUE_60)) begin
			sector = 3'd3;
			hm = 12'(h - 15'(3 * rhc_pkg::HUE_60));
		end else if (h >= 15'(2 * rhc_pkg::HUE_60)) begin
			sector = 3'd2;
			hm = 12'(h - 15'(2 * rhc_pkg::HUE_60));
		end else if (h >= 15'(rhc_pkg::HUE_60)) begin
			sector = 3'd1;
			hm = 12'(h - 15'(rhc_pkg::HUE_60));
		end else begin
			sector = 3'd0;
			hm = 12'(h);
		end
		two_l = {src_data.in_light, 1'b0};
		dev = (two_l >= 14'(rhc_pkg::UNIT_ONE)) ? two_l - 14'(rhc_pkg::UNIT_ONE)
			: 14'(rhc_pkg::UNIT_ONE) - two_l;
		onemin = 13'(14'(rhc_pkg::UNIT_ONE) - dev);

		item.dir = rhc_pkg::dir_t'(direction);
		item.err = (src_data.in_hue > 15'(rhc_pkg::HUE_360))
			|| (src_data.in_sat > 13'(rhc_pkg::UNIT_ONE))
			|| (src_data.in_light > 13'(rhc_pkg::UNIT_ONE));
		item.nh = 24'(total) * 24'(rhc_pkg::HUE_60) + 24'(c >> 1);
		item.d  = (sum >= 9'd255) ? 8'(9'd510 - sum) : 8'(sum);
		item.ns = {4'd0, c, 12'd0} + 24'(item.d >> 1);
		item.nl = {3'd0, sum, 12'd0} + 24'd255;
		item.c  = c;
		item.cs = 25'(26'(onemin) * 26'(src_data.in_sat));
		item.l  = src_data.in_light;
		item.w  = sector[0] ? 12'(rhc_pkg::HUE_60) - hm : hm;
		item.sector = sector;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_v_q <= 1'b0;
		end else if (take) begin
			fr_v_q <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && src_valid) begin
			item_q <= item;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rhc_fifo.sv
// ----------------------------------------------------------------------------
// rhc_fifo
// Short queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire rhc_pkg::item_t      push_item,
	input  wire logic                pop,
	output rhc_pkg::item_t           pop_item,
	output rhc_pkg::fifo_stat_t      stat
);

	localparam int AW = $clog2(rhc_pkg::FIFO_DEPTH);

	rhc_pkg::item_t mem [rhc_pkg::FIFO_DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;

	assign stat.full  = (cnt_q == (AW+1)'(rhc_pkg::FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_item   = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rhc_back.sv
// ----------------------------------------------------------------------------
// rhc_back
// Three-stage execution pipeline: divisions for RGB to HSL and scaled
// products for HSL to RGB, ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rhc_pkg::fifo_stat_t fifo_stat,
	input  wire rhc_pkg::item_t      pop_item,
	output logic                     pop,
	output logic                     dst_valid,
	input  wire logic                dst_stall,
	output rhc_pkg::pix_out_t        dst_data
);

	logic en;
	logic v_s1, v_s2, v_s3;
	logic [14:0] qh, qs, ql;

	rhc_pkg::dir_t dir_s1, dir_s2, dir_s3;
	logic          err_s1, err_s2;
	logic          zc_s1, zc_s2, zc_s3;
	logic [2:0]    sector_s1, sector_s2;
	logic [24:0]   cs_s1;
	logic [36:0]   p_s1;
	logic [37:0]   m_s1;
	logic [7:0]    bc_s2, bx_s2, b0_s2;
	logic [7:0]    red_s3, green_s3, blue_s3;
	logic          rerr_s3;
	logic [37:0]   numc, numx;
	logic [25:0]   lm;

	function automatic logic [7:0] to_byte(input logic [37:0] num);
		logic [42:0] t;
		t = 43'({num, 4'd0}) + 43'(num);
		return (t[42:33] > 10'd255) ? 8'd255 : t[40:33];
	endfunction

	assign en   = !(v_s3 && dst_stall);
	assign pop  = en && !fifo_stat.empty;
	assign lm   = {pop_item.l, 13'd0} - 26'(pop_item.cs);
	assign numc = 38'(cs_s1) * 38'(2 * rhc_pkg::HUE_60) + m_s1;
	assign numx = {p_s1, 1'b0} + m_s1;

	rhc_div u_div_hue (
		.clk(clk), .en(en), .n(pop_item.nh), .dv({1'b0, pop_item.c}),
		.recip(rhc_pkg::RECIP_TAB[pop_item.c]), .q(qh)
	);

	rhc_div u_div_sat (
		.clk(clk), .en(en), .n(pop_item.ns), .dv({1'b0, pop_item.d}),
		.recip(rhc_pkg::RECIP_TAB[pop_item.d]), .q(qs)
	);

	rhc_div u_div_light (
		.clk(clk), .en(en), .n(pop_item.nl), .dv(9'd510),
		.recip(rhc_pkg::RECIP_510), .q(ql)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_s1    <= pop_item.dir;
			err_s1    <= pop_item.err;
			zc_s1     <= (pop_item.c == 8'd0);
			sector_s1 <= pop_item.sector;
			cs_s1     <= pop_item.cs;
			p_s1      <= 37'(pop_item.cs) * 37'(pop_item.w);
			m_s1      <= 38'(lm) * 38'(rhc_pkg::HUE_60);

			dir_s2    <= dir_s1;
			err_s2    <= err_s1;
			zc_s2     <= zc_s1;
			sector_s2 <= sector_s1;
			bc_s2     <= to_byte(numc);
			bx_s2     <= to_byte(numx);
			b0_s2     <= to_byte(m_s1);

			dir_s3    <= dir_s2;
			zc_s3     <= zc_s2;
			rerr_s3   <= (dir_s2 == rhc_pkg::DIR_HSL2RGB) && err_s2;
			if (dir_s2 == rhc_pkg::DIR_RGB2HSL || err_s2) begin
				red_s3   <= 8'd0;
				green_s3 <= 8'd0;
				blue_s3  <= 8'd0;
			end else begin
				case (sector_s2)
					3'd0: begin
						red_s3 <= bc_s2; green_s3 <= bx_s2; blue_s3 <= b0_s2;
					end
					3'd1: begin
						red_s3 <= bx_s2; green_s3 <= bc_s2; blue_s3 <= b0_s2;
					end
					3'd2: begin
						red_s3 <= b0_s2; green_s3 <= bc_s2; blue_s3 <= bx_s2;
					end
					3'd3: begin
						red_s3 <= b0_s2; green_s3 <= bx_s2; blue_s3 <= bc_s2;
					end
					3'd4: begin
						red_s3 <= bx_s2; green_s3 <= b0_s2; blue_s3 <= bc_s2;
					end
					default: begin
						red_s3 <= bc_s2; green_s3 <= b0_s2; blue_s3 <= bx_s2;
					end
				endcase
			end
		end
	end

	always_comb begin
		dst_valid          = v_s3;
		dst_data.out_red   = red_s3;
		dst_data.out_green = green_s3;
		dst_data.out_blue  = blue_s3;
		dst_data.range_error = rerr_s3;
		if (dir_s3 == rhc_pkg::DIR_RGB2HSL) begin
			dst_data.out_light = 13'(ql);
			if (zc_s3) begin
				dst_data.out_hue = 15'd0;
				dst_data.out_sat = 13'd0;
			end else begin
				dst_data.out_hue = (qh >= 15'(rhc_pkg::HUE_360)) ? 15'd0 : qh;
				dst_data.out_sat = 13'(qs);
			end
		end else begin
			dst_data.out_hue   = 15'd0;
			dst_data.out_sat   = 13'd0;
			dst_data.out_light = 13'd0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rgb_hsl_color_converter.sv
// ----------------------------------------------------------------------------
// rgb_hsl_color_converter
// Pixel converter between 8-bit RGB and fixed-point HSL.
//
// The src channel carries one pixel per beat and the dst channel one result
// per beat; both use valid and stall. The direction register (APB, address
// 0, bit 0) selects RGB to HSL (0) or HSL to RGB (1) and is sampled with
// each pixel as it enters.
// Throughput is one pixel per clock while dst is not stalled. With an empty
// queue an accepted pixel passes the front register, the queue and the back
// end's three stages before dst_valid rises; the stages are set by the
// reciprocal dividers' multiply, multiply-back and correction steps.
// When dst is stalled the back pipeline holds and the queue fills; src
// stalls only once the queue and the front register are full.
// Reset clears the pipeline, the queue and the direction register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_hsl_color_converter (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              src_valid,
	output logic                   src_stall,
	input  wire rhc_pkg::pix_in_t  src_data,
	output logic                   dst_valid,
	input  wire logic              dst_stall,
	output rhc_pkg::pix_out_t      dst_data
);

	logic                direction_q;
	logic                push, pop;
	rhc_pkg::item_t      push_item, pop_item;
	rhc_pkg::fifo_stat_t fifo_stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == rhc_pkg::REG_DIRECTION) ? {31'd0, direction_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == rhc_pkg::REG_DIRECTION) begin
			direction_q <= pwdata[0];
		end
	end

	rhc_front u_front (
		.clk(clk), .arst_n(arst_n), .direction(direction_q),
		.src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
		.fifo_stat(fifo_stat), .push(push), .push_item(push_item)
	);

	rhc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.pop(pop), .pop_item(pop_item), .stat(fifo_stat)
	);

	rhc_back u_back (
		.clk(clk), .arst_n(arst_n), .fifo_stat(fifo_stat), .pop_item(pop_item),
		.pop(pop), .dst_valid(dst_valid), .dst_stall(dst_stall), .dst_data(dst_data)
	);

endmodule

`default_nettype wire

FILE: rtl/core/rhc_checker.sv
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rhc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              dst_valid,
	input wire logic              dst_stall,
	input wire rhc_pkg::pix_out_t dst_data
);

	logic err_fields_zero;
	logic hsl_in_range;

	assign err_fields_zero = dst_data.out_red == 8'd0 && dst_data.out_green == 8'd0
		&& dst_data.out_blue == 8'd0 && dst_data.out_hue == 15'd0;
	assign hsl_in_range = dst_data.out_hue < 15'(rhc_pkg::HUE_360)
		&& dst_data.out_sat <= 13'(rhc_pkg::UNIT_ONE)
		&& dst_data.out_light <= 13'(rhc_pkg::UNIT_ONE);

	`RHC_ASSERT_NEXT(a_hold_valid, dst_valid && dst_stall, dst_valid)
	`RHC_ASSERT_NEXT(a_hold_data, dst_valid && dst_stall, $stable(dst_data))
	`RHC_ASSERT_IMPLY(a_err_zero, dst_valid && dst_data.range_error, err_fields_zero)
	`RHC_ASSERT_IMPLY(a_hsl_range, dst_valid, hsl_in_range)

endmodule

bind rgb_hsl_color_converter rhc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .dst_valid(dst_valid),
	.dst_stall(dst_stall), .dst_data(dst_data)
);

`default_nettype wire

FILE: tb/rgb_hsl_color_converter_checker.sv
// ----------------------------------------------------------------------------
// rgb_hsl_color_converter_checker
// Watches the pixel and result channels and the register port of the color
// converter, computes the expected conversion of every accepted pixel under
// the direction in force when it entered, and compares each accepted result
// field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_hsl_color_converter_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic              pready,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	input  wire logic              src_valid,
	input  wire logic              src_stall,
	input  wire rhc_pkg::pix_in_t  src_data,
	input  wire logic              dst_valid,
	input  wire logic              dst_stall,
	input  wire rhc_pkg::pix_out_t dst_data,
	output int                     failures,
	output int                     pending,
	output int                     checked
);
	timeunit 1ns;
	timeprecision 1ps;

	rhc_pkg::dir_t     cur_dir;
	rhc_pkg::pix_out_t expected_pixels[$];

	function automatic rhc_pkg::pix_out_t convert_rgb(logic [7:0] r, logic [7:0] g,
		logic [7:0] b);
		rhc_pkg::pix_out_t o;
		longint mx, mn, c, sum, d, total, hue, sat;
		o = '0;
		mx = r; mn = r; total = 0; hue = 0; sat = 0;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		c = mx - mn;
		sum = mx + mn;
		if (c != 0) begin
			if (mx == r) total = (g >= b) ? (g - b) : (6 * c - (b - g));
			else if (mx == g) total = 2 * c + b - r;
			else total = 4 * c + r - g;
			hue = (total * rhc_pkg::HUE_60 + c / 2) / c;
			if (hue >= rhc_pkg::HUE_360) hue = 0;
			d = (sum >= 255) ? (510 - sum) : sum;
			sat = (c * rhc_pkg::UNIT_ONE + d / 2) / d;
		end
		o.out_hue = hue[14:0];
		o.out_sat = sat[12:0];
		o.out_light = 13'((sum * rhc_pkg::UNIT_ONE + 255) / 510);
		return o;
	endfunction

	function automatic logic [7:0] scale_byte(longint num, longint den);
		longint v;
		v = (num * 255) / den;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic rhc_pkg::pix_out_t convert_hsl(longint h, longint s, longint l);
		rhc_pkg::pix_out_t o;
		longint one, h60, dev, cs, hr, hdev, cc, xx, mm, den, p0, p1, p2;
		o = '0;
		one = rhc_pkg::UNIT_ONE;
		h60 = rhc_pkg::HUE_60;
		if (h > rhc_pkg::HUE_360 || s > one || l > one) begin
			o.range_error = 1'b1;
			return o;
		end
		if (h == rhc_pkg::HUE_360) h = 0;
		dev = (2 * l >= one) ? (2 * l - one) : (one - 2 * l);
		cs = (one - dev) * s;
		hr = h % (2 * h60);
		hdev = (hr >= h60) ? (hr - h60) : (h60 - hr);
		den = 2 * one * one * h60;
		cc = cs * 2 * h60;
		xx = cs * 2 * (h60 - hdev);
		mm = l * one * 2 * h60 - cs * h60;
		case (h / h60)
			0: begin p0 = cc; p1 = xx; p2 = 0; end
			1: begin p0 = xx; p1 = cc; p2 = 0; end
			2: begin p0 = 0; p1 = cc; p2 = xx; end
			3: begin p0 = 0; p1 = xx; p2 = cc; end
			4: begin p0 = xx; p1 = 0; p2 = cc; end
			default: begin p0 = cc; p1 = 0; p2 = xx; end
		endcase
		o.out_red = scale_byte(p0 + mm, den);
		o.out_green = scale_byte(p1 + mm, den);
		o.out_blue = scale_byte(p2 + mm, den);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rhc_pkg::pix_out_t e;
		if (!arst_n) begin
			cur_dir <= rhc_pkg::DIR_RGB2HSL;
			expected_pixels.delete();
			failures <= 0;
			checked <= 0;
		end else begin
			if (psel && penable && pwrite && pready
				&& paddr == 3'(4 * rhc_pkg::REG_DIRECTION))
				cur_dir <= rhc_pkg::dir_t'(pwdata[0]);
			if (src_valid && !src_stall) begin
				if (cur_dir == rhc_pkg::DIR_RGB2HSL)
					expected_pixels.push_back(convert_rgb(src_data.in_red,
						src_data.in_green, src_data.in_blue));
				else
					expected_pixels.push_back(convert_hsl(src_data.in_hue,
						src_data.in_sat, src_data.in_light));
			end
			if (dst_valid && !dst_stall) begin
				checked <= checked + 1;
				if (expected_pixels.size() == 0) begin
					$error("result beat with no pixel outstanding");
					failures <= failures + 1;
				end else begin
					e = expected_pixels.pop_front();
					if (e != dst_data) failures <= failures + 1;
					if (e.out_red != dst_data.out_red)
						$error("out_red exp %0d got %0d", e.out_red, dst_data.out_red);
					if (e.out_green != dst_data.out_green)
						$error("out_green exp %0d got %0d", e.out_green, dst_data.out_green);
					if (e.out_blue != dst_data.out_blue)
						$error("out_blue exp %0d got %0d", e.out_blue, dst_data.out_blue);
					if (e.out_hue != dst_data.out_hue)
						$error("out_hue exp %0d got %0d", e.out_hue, dst_data.out_hue);
					if (e.out_sat != dst_data.out_sat)
						$error("out_sat exp %0d got %0d", e.out_sat, dst_data.out_sat);
					if (e.out_light != dst_data.out_light)
						$error("out_light exp %0d got %0d", e.out_light, dst_data.out_light);
					if (e.range_error != dst_data.range_error)
						$error("range_error exp %0d got %0d", e.range_error,
							dst_data.range_error);
				end
			end
		end
	end

	assign pending = expected_pixels.size();

endmodule

`default_nettype wire

FILE: tb/rgb_hsl_color_converter_tb.sv
// ----------------------------------------------------------------------------
// rgb_hsl_color_converter_tb
// Drives pixels into the color converter in both directions, with directed
// corner pixels followed by random ones, random gaps and output stalls, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_hsl_color_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite, pready;
	logic [2:0]        paddr;
	logic [31:0]       pwdata, prdata;
	logic              src_valid, src_stall, dst_valid, dst_stall;
	rhc_pkg::pix_in_t  src_data;
	rhc_pkg::pix_out_t dst_data;
	int                failures, pending, checked;
	int                pixels_sent;
	logic              stall_enable;

	rgb_hsl_color_converter dut (.*);

	rgb_hsl_color_converter_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int gap_length();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60) return 0;
		if (k < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) dst_stall <= 1'b0;
		else if (!stall_enable) dst_stall <= 1'b0;
		else if (dst_stall) dst_stall <= ($urandom_range(0, 99) < 70);
		else dst_stall <= ($urandom_range(0, 99) < 25);
	end

	task automatic set_direction(rhc_pkg::dir_t d);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'(4 * rhc_pkg::REG_DIRECTION); pwdata <= 32'(d);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic wait_empty();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic drain();
		wait_empty();
		repeat (10) @(posedge clk);
	endtask

	task automatic send_pixel(rhc_pkg::pix_in_t p);
		int g;
		g = gap_length();
		if (g > 0) begin
			src_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_data <= p;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		pixels_sent++;
	endtask

	task automatic send_rgb(int r, int g, int b);
		rhc_pkg::pix_in_t p;
		p = rhc_pkg::pix_in_t'($urandom());
		p.in_hue = 15'($urandom());
		p.in_red = 8'(r); p.in_green = 8'(g); p.in_blue = 8'(b);
		send_pixel(p);
	endtask

	task automatic send_hsl(int h, int s, int l);
		rhc_pkg::pix_in_t p;
		p.in_red = 8'($urandom()); p.in_green = 8'($urandom());
		p.in_blue = 8'($urandom());
		p.in_hue = 15'(h); p.in_sat = 13'(s); p.in_light = 13'(l);
		send_pixel(p);
	endtask

	task automatic random_phase(rhc_pkg::dir_t d, int n);
		int k;
		set_direction(d);
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (d == rhc_pkg::DIR_RGB2HSL) begin
				if (k < 15) begin
					k = $urandom_range(0, 255);
					send_rgb(k, k, (k < 4) ? k : $urandom_range(k - 2, k));
				end else
					send_rgb($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255));
			end else if (k < 85)
				send_hsl($urandom_range(0, rhc_pkg::HUE_360),
					$urandom_range(0, rhc_pkg::UNIT_ONE),
					$urandom_range(0, rhc_pkg::UNIT_ONE));
			else
				send_hsl($urandom_range(0, 32767), $urandom_range(0, 8191),
					$urandom_range(0, 8191));
			if (i == n / 2) begin
				src_valid <= 1'b0;
				wait_empty();
			end
		end
		src_valid <= 1'b0;
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		src_valid = 1'b0; src_data = '0; stall_enable = 1'b0;
		pixels_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		stall_enable <= 1'b1;

		send_rgb(0, 0, 0);
		send_rgb(255, 255, 255);
		send_rgb(255, 0, 0);
		send_rgb(0, 255, 0);
		send_rgb(0, 0, 255);
		send_rgb(255, 255, 0);
		send_rgb(0, 255, 255);
		send_rgb(255, 0, 1);
		send_rgb(128, 128, 128);
		send_rgb(200, 100, 100);
		src_valid <= 1'b0;
		drain();

		set_direction(rhc_pkg::DIR_HSL2RGB);
		send_hsl(0, 0, 0);
		send_hsl(0, rhc_pkg::UNIT_ONE, rhc_pkg::UNIT_ONE / 2);
		send_hsl(rhc_pkg::HUE_360, rhc_pkg::UNIT_ONE, rhc_pkg::UNIT_ONE / 2);
		send_hsl(rhc_pkg::HUE_360 + 1, 0, 0);
		send_hsl(0, rhc_pkg::UNIT_ONE + 1, 0);
		send_hsl(0, 0, rhc_pkg::UNIT_ONE + 1);
		send_hsl(32767, 8191, 8191);
		send_hsl(rhc_pkg::HUE_60, rhc_pkg::UNIT_ONE, rhc_pkg::UNIT_ONE);
		send_hsl(3 * rhc_pkg::HUE_60 + 7, 2000, 3000);
		send_hsl(5 * rhc_pkg::HUE_60 + 100, rhc_pkg::UNIT_ONE, 1000);
		src_valid <= 1'b0;
		drain();

		random_phase(rhc_pkg::DIR_RGB2HSL, 500);
		random_phase(rhc_pkg::DIR_HSL2RGB, 500);
		stall_enable <= 1'b0;
		random_phase(rhc_pkg::DIR_RGB2HSL, 150);
		stall_enable <= 1'b1;
		random_phase(rhc_pkg::DIR_HSL2RGB, 400);

		$display("Sent %0d pixels in both directions, %0d results checked.",
			pixels_sent, checked);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
